// File: hw/rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
package stq_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ARM     = 2'd1,
    CMD_DISARM  = 2'd2,
    CMD_SERVICE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_REMOVE,
    ST_SERVICE,
    ST_INSERT,
    ST_SCHED,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch the request payload
    logic tick;        // advance the tick counter
    logic rm_id;       // remove the addressed timer, set up its re-insertion
    logic arm;         // with rm_id: the request is an arm, so record its period
    logic rm_head;     // pop the head for service
    logic insert;      // insert the pending entry
    logic sched;       // reprogram the alarm
  } stq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_valid;    // addressed timer is within range
    logic found;       // addressed timer sits in the queue
    logic found_head;  // ... and it is the head
    logic can_service; // queue not empty and alarm has fired
    logic period_nz;   // popped head is periodic
  } stq_stat_t;

  localparam logic [15:0] MinLeadReset = 16'd50;

endpackage

// File: hw/rtl/sorted_software_timer_queue.sv
// Sorted timer queue with a single alarm: controller and datapath top level.
// Steps: a tick runs TICK, DONE; an arm REMOVE, INSERT, SCHED, DONE; a disarm REMOVE,
// then SCHED if it took the head, then DONE; an id out of range ends REMOVE in DONE; a
// service SERVICE, then INSERT if periodic, SCHED, DONE, or DONE if nothing is due.
// Busy stays high; one request at a time, the next start taken the cycle after done.
// Reset clears the tick counter, alarm, queue length, periods and sets min_lead to 50.
// Results are marked by done_o high for one cycle; the receiver cannot stall them.
module sorted_software_timer_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic        min_lead_we_i,
  input  logic [15:0] min_lead_i,
  input  logic [1:0]  command_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] ticks_i,
  input  logic        repeat_req_i,
  output logic        fired_o,
  output logic [3:0]  fired_id_o,
  output logic        alarm_pending_o,
  output logic [31:0] next_alarm_o,
  output logic [4:0]  queued_count_o
);
  import stq_pkg::*;

  stq_ctrl_t ctrl;
  stq_stat_t stat;

  // The controller decodes each request and steps the datapath through it.
  stq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  // The datapath holds the sorted queue, the periods, the tick counter and the alarm.
  stq_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .min_lead_we_i   (min_lead_we_i),
    .min_lead_i      (min_lead_i),
    .timer_id_i      (timer_id_i),
    .ticks_i         (ticks_i),
    .repeat_req_i    (repeat_req_i),
    .fired_o         (fired_o),
    .fired_id_o      (fired_id_o),
    .alarm_pending_o (alarm_pending_o),
    .next_alarm_o    (next_alarm_o),
    .queued_count_o  (queued_count_o)
  );

endmodule

// File: hw/rtl/stq_ctrl.sv
// Controller state machine that sequences each timer queue request.
module stq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  stq_pkg::stq_stat_t stat_i,
  output stq_pkg::stq_ctrl_t ctrl_o,
  output logic              busy_o,
  output logic              done_o
);
  import stq_pkg::*;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_TICK;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ctrl_o  = '0;
    busy_o  = (state_q != ST_IDLE);
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          cmd_d       = cmd_e'(command_i);
          unique case (cmd_e'(command_i))
            CMD_TICK:              state_d = ST_TICK;
            CMD_ARM, CMD_DISARM:   state_d = ST_REMOVE;
            CMD_SERVICE:           state_d = ST_SERVICE;
            default:               state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK: begin
        ctrl_o.tick = 1'b1;
        state_d     = ST_DONE;
      end
      ST_REMOVE: begin
        if (!stat_i.id_valid) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.rm_id = 1'b1;
          if (cmd_q == CMD_ARM) begin
            ctrl_o.arm = 1'b1;
            state_d    = ST_INSERT;
          end else if (stat_i.found_head) begin
            state_d = ST_SCHED;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SERVICE: begin
        if (stat_i.can_service) begin
          ctrl_o.rm_head = 1'b1;
          state_d        = stat_i.period_nz ? ST_INSERT : ST_SCHED;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_INSERT: begin
        ctrl_o.insert = 1'b1;
        state_d       = ST_SCHED;
      end
      ST_SCHED: begin
        ctrl_o.sched = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/stq_datapath.sv
// Datapath of the timer queue: sorted entry registers, tick counter and alarm.
module stq_datapath #(
  parameter int NUM_TIMERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stq_pkg::stq_ctrl_t ctrl_i,
  output stq_pkg::stq_stat_t stat_o,
  input  logic               min_lead_we_i,
  input  logic [15:0]        min_lead_i,
  input  logic [3:0]         timer_id_i,
  input  logic [31:0]        ticks_i,
  input  logic               repeat_req_i,
  output logic               fired_o,
  output logic [3:0]         fired_id_o,
  output logic               alarm_pending_o,
  output logic [31:0]        next_alarm_o,
  output logic [4:0]         queued_count_o
);
  import stq_pkg::*;

  localparam int LenW = $clog2(NUM_TIMERS + 1);
  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [15:0]     min_lead_q;
  logic [31:0]     now_q, alarm_q, ticks_q, ins_exp_q;
  logic            armed_q, rep_q, fired_q;
  logic [3:0]      id_q, ins_id_q, fired_id_q;
  logic [LenW-1:0] len_q;
  logic [3:0]      ids_q    [NUM_TIMERS];
  logic [31:0]     exp_q    [NUM_TIMERS];
  logic [31:0]     period_q [NUM_TIMERS];

  logic [3:0]      ids_d    [NUM_TIMERS];
  logic [31:0]     exp_d    [NUM_TIMERS];
  logic [LenW-1:0] len_d;

  logic [NUM_TIMERS-1:0] match, gt, rm_aft, ins_aft;
  logic [31:0]     head_period, lead, head_diff, diff;
  logic            id_valid;

  assign id_valid    = (32'(id_q) < NUM_TIMERS);
  assign head_period = period_q[IdxW'(ids_q[0])];

  // Search for the entry to remove and for the insertion point.
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      match[i] = (LenW'(i) < len_q) &&
                 (ctrl_i.rm_head ? (i == 0) : (ids_q[i] == id_q));
      diff     = exp_q[i] - ins_exp_q;
      gt[i]    = ((LenW'(i) < len_q) && (diff != 32'd0) && !diff[31]) ||
                 (LenW'(i) == len_q);
    end
    rm_aft[0]  = match[0];
    ins_aft[0] = gt[0];
    for (int i = 1; i < NUM_TIMERS; i++) begin
      rm_aft[i]  = rm_aft[i-1] | match[i];
      ins_aft[i] = ins_aft[i-1] | gt[i];
    end
  end

  // Next queue contents: shift down on removal, open a gap on insertion.
  always_comb begin
    len_d = len_q;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ids_d[i] = ids_q[i];
      exp_d[i] = exp_q[i];
    end
    if ((ctrl_i.rm_id || ctrl_i.rm_head) && (|match)) begin
      len_d = len_q - 1'b1;
      for (int i = 0; i + 1 < NUM_TIMERS; i++) begin
        if (rm_aft[i]) begin
          ids_d[i] = ids_q[i+1];
          exp_d[i] = exp_q[i+1];
        end
      end
    end else if (ctrl_i.insert && (32'(len_q) < NUM_TIMERS)) begin
      len_d = len_q + 1'b1;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (ins_aft[i]) begin
          if (i == 0 || !ins_aft[(i == 0) ? 0 : i-1]) begin
            ids_d[i] = ins_id_q;
            exp_d[i] = ins_exp_q;
          end else begin
            ids_d[i] = ids_q[(i == 0) ? 0 : i-1];
            exp_d[i] = exp_q[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  assign lead      = (min_lead_q == 16'd0) ? 32'd1 : 32'(min_lead_q);
  assign head_diff = exp_q[0] - now_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ids_q[i] <= ids_d[i];
      exp_q[i] <= exp_d[i];
    end
    if (ctrl_i.load) begin
      id_q    <= timer_id_i;
      ticks_q <= ticks_i;
      rep_q   <= repeat_req_i;
    end
    if (ctrl_i.rm_id) begin
      ins_exp_q <= now_q + ticks_q;
      ins_id_q  <= id_q;
    end else if (ctrl_i.rm_head) begin
      ins_exp_q <= exp_q[0] + head_period;
      ins_id_q  <= ids_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lead_q <= MinLeadReset;
      now_q      <= '0;
      alarm_q    <= '0;
      armed_q    <= 1'b0;
      len_q      <= '0;
      fired_q    <= 1'b0;
      fired_id_q <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) period_q[i] <= '0;
    end else begin
      if (min_lead_we_i) min_lead_q <= min_lead_i;
      len_q <= len_d;
      if (ctrl_i.load) begin
        fired_q    <= 1'b0;
        fired_id_q <= '0;
      end
      if (ctrl_i.tick) begin
        if (armed_q && ((alarm_q - now_q - 32'd1) < ticks_q)) armed_q <= 1'b0;
        now_q <= now_q + ticks_q;
      end
      // Arm requests carry a period; a one-shot arm clears it.
      if (ctrl_i.rm_id && ctrl_i.arm) begin
        period_q[IdxW'(id_q)] <= rep_q ? ticks_q : 32'd0;
      end
      if (ctrl_i.rm_head) begin
        fired_q    <= 1'b1;
        fired_id_q <= ids_q[0];
      end
      if (ctrl_i.sched) begin
        if (len_q == '0) begin
          armed_q <= 1'b0;
        end else begin
          armed_q <= 1'b1;
          alarm_q <= (head_diff[31] || (head_diff < lead)) ? (now_q + lead) : exp_q[0];
        end
      end
    end
  end

  assign stat_o.id_valid    = id_valid;
  assign stat_o.found       = |match;
  assign stat_o.found_head  = match[0];
  assign stat_o.can_service = (len_q != '0) && !armed_q;
  assign stat_o.period_nz   = (head_period != 32'd0);

  assign fired_o         = fired_q;
  assign fired_id_o      = fired_id_q;
  assign alarm_pending_o = armed_q;
  assign next_alarm_o    = alarm_q;
  assign queued_count_o  = 5'(len_q);

endmodule

// File: bench/tb_sorted_software_timer_queue.sv
// Self-checking testbench for the sorted software timer queue with a single alarm.
`timescale 1ns / 1ps

module tb_sorted_software_timer_queue;
  import stq_pkg::*;

  // A request as presented to the block.
  typedef struct {
    cmd_e        cmd;
    logic [3:0]  id;
    logic [31:0] ticks;
    logic        rep;
  } timer_req_t;

  // The status the block reports once a request has been carried out.
  typedef struct {
    logic        fired;
    logic [3:0]  fired_id;
    logic        pending;
    logic [31:0] alarm_at;
    logic [4:0]  count;
  } timer_status_t;

  localparam int NumSlots      = 16;
  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        min_lead_we_i = 1'b0;
  logic [15:0] min_lead_i = MinLeadReset;
  logic [1:0]  command_i = CMD_TICK;
  logic [3:0]  timer_id_i = '0;
  logic [31:0] ticks_i = '0;
  logic        repeat_req_i = 1'b0;
  logic        busy_o, done_o, fired_o, alarm_pending_o;
  logic [3:0]  fired_id_o;
  logic [31:0] next_alarm_o;
  logic [4:0]  queued_count_o;

  sorted_software_timer_queue #(.NUM_TIMERS(NumSlots)) DUT (.*);

  always #5 clk_i = ~clk_i;

  // Requests still to be sent, and the status each sent request should produce.
  timer_req_t    pending_reqs[$];
  timer_status_t expected_status[$];
  timer_req_t    held_req;
  int            sender_gap_pct = 0;
  int            error_count = 0;
  int            accepted_count = 0;
  int            fired_count = 0;
  int            watchdog = 0;

  // Our own copy of the block's state, updated as each request is accepted.
  logic [15:0] lead_reg = MinLeadReset;
  logic [31:0] now_ticks = '0;
  logic [31:0] alarm_at = '0;
  logic        alarm_on = 1'b0;
  logic [3:0]  slot_id[NumSlots];
  logic [31:0] slot_expiry[NumSlots];
  int          queue_len = 0;
  logic [31:0] period[NumSlots];
  logic        in_queue[NumSlots];

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      period[i] = '0;
      in_queue[i] = 1'b0;
    end
  end

  // True when a lies strictly after b on the wrapping tick line.
  function automatic logic is_later(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && !d[31];
  endfunction

  // Programme the alarm to the head expiry, but never closer than the lead to now.
  function automatic void reschedule_alarm();
    logic [31:0] lead, d;
    lead = (lead_reg == 0) ? 32'd1 : {16'd0, lead_reg};
    if (queue_len == 0) begin
      alarm_on = 1'b0;
      return;
    end
    d = slot_expiry[0] - now_ticks;
    if (d[31] || d < lead) alarm_at = now_ticks + lead;
    else alarm_at = slot_expiry[0];
    alarm_on = 1'b1;
  endfunction

  // Timers with equal expiry stay in arrival order, so we skip past them.
  function automatic void enqueue_timer(logic [31:0] expiry, logic [3:0] id);
    int pos;
    pos = 0;
    if (queue_len >= NumSlots) return;
    while (pos < queue_len && !is_later(slot_expiry[pos], expiry)) pos++;
    for (int i = queue_len; i > pos; i--) begin
      slot_id[i] = slot_id[i-1];
      slot_expiry[i] = slot_expiry[i-1];
    end
    slot_id[pos] = id;
    slot_expiry[pos] = expiry;
    queue_len++;
    in_queue[id] = 1'b1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < queue_len; i++) begin
      slot_id[i] = slot_id[i+1];
      slot_expiry[i] = slot_expiry[i+1];
    end
    queue_len--;
  endfunction

  // The alarm only moves when the timer taken out was at the head.
  function automatic void cancel_timer(logic [3:0] id);
    int pos;
    if (!in_queue[id] || queue_len == 0) return;
    for (pos = 0; pos < queue_len; pos++)
      if (slot_id[pos] == id) break;
    if (pos < queue_len) begin
      drop_entry(pos);
      if (pos == 0) reschedule_alarm();
    end
    in_queue[id] = 1'b0;
  endfunction

  // Carries out one request on our copy of the state and returns the status expected.
  function automatic timer_status_t apply_request(timer_req_t r);
    timer_status_t s;
    logic [3:0]    head_id;
    logic [31:0]   head_exp;
    s.fired = 1'b0;
    s.fired_id = '0;
    case (r.cmd)
      CMD_TICK: begin
        if (r.ticks != 0) begin
          // The alarm goes off when its time falls in (old now, new now].
          if (alarm_on && (alarm_at - now_ticks - 32'd1) < r.ticks) alarm_on = 1'b0;
          now_ticks += r.ticks;
        end
      end
      CMD_ARM: begin
        cancel_timer(r.id);
        period[r.id] = r.rep ? r.ticks : '0;
        enqueue_timer(now_ticks + r.ticks, r.id);
        reschedule_alarm();
      end
      CMD_DISARM: cancel_timer(r.id);
      default: begin
        // Servicing does nothing until the alarm has gone off.
        if (queue_len != 0 && !alarm_on) begin
          head_id = slot_id[0];
          head_exp = slot_expiry[0];
          drop_entry(0);
          in_queue[head_id] = 1'b0;
          if (period[head_id] != 0) enqueue_timer(head_exp + period[head_id], head_id);
          reschedule_alarm();
          s.fired = 1'b1;
          s.fired_id = head_id;
        end
      end
    endcase
    s.pending = alarm_on;
    s.alarm_at = alarm_at;
    s.count = queue_len[4:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: a request is taken when start is high and busy is low at the edge. Once
  // start has been raised it is held until the request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_status.push_back(apply_request(held_req));
        accepted_count++;
      end
      if (start_i && busy_o) begin
        // Still waiting for the block to take the held request.
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        held_req = pending_reqs.pop_front();
        start_i <= 1'b1;
        command_i <= held_req.cmd;
        timer_id_i <= held_req.id;
        ticks_i <= held_req.ticks;
        repeat_req_i <= held_req.rep;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: each status is checked against the expected one when done marks it on the ports.
  always @(posedge clk_i) begin
    timer_status_t want;
    if (rst_ni && done_o) begin
      if (expected_status.size() == 0) begin
        $display("MISMATCH at %0t: status reported with no request outstanding", $realtime);
        error_count++;
      end else begin
        want = expected_status.pop_front();
        if (fired_o !== want.fired) report_mismatch("fired", fired_o, want.fired);
        if (fired_id_o !== want.fired_id) report_mismatch("fired_id", fired_id_o, want.fired_id);
        if (alarm_pending_o !== want.pending)
          report_mismatch("alarm_pending", alarm_pending_o, want.pending);
        if (next_alarm_o !== want.alarm_at)
          report_mismatch("next_alarm", next_alarm_o, want.alarm_at);
        if (queued_count_o !== want.count)
          report_mismatch("queued_count", queued_count_o, want.count);
        if (want.fired) fired_count++;
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a status moves.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WatchdogLimit) begin
      $display("Timeout: no progress for %0d cycles", WatchdogLimit);
      $display("tb_sorted_software_timer_queue: done, errors");
      $finish;
    end
  end

  function automatic timer_req_t mk(cmd_e c, int id, logic [31:0] t, logic rep);
    timer_req_t r;
    r.cmd = c;
    r.id = id[3:0];
    r.ticks = t;
    r.rep = rep;
    return r;
  endfunction

  // Mostly small delays so that alarms go off and services pop, with the odd
  // full-range value and delays close to a wrap of the tick counter.
  function automatic timer_req_t random_request();
    int          pick, shape;
    logic [31:0] t;
    pick = $urandom_range(99);
    shape = $urandom_range(99);
    if (pick < 35) begin
      if (shape < 70) t = $urandom_range(120, 1);
      else if (shape < 80) t = '0;
      else if (shape < 90) t = $urandom;
      else t = $urandom_range(2000, 1);
      return mk(CMD_TICK, $urandom_range(15), t, $urandom_range(1));
    end else if (pick < 65) begin
      if (shape < 75) t = $urandom_range(300);
      else if (shape < 90) t = $urandom;
      else t = 32'hFFFF_FF00 + $urandom_range(255);
      return mk(CMD_ARM, $urandom_range(15), t, $urandom_range(1));
    end else if (pick < 75) begin
      return mk(CMD_DISARM, $urandom_range(15), $urandom, $urandom_range(1));
    end
    return mk(CMD_SERVICE, $urandom_range(15), $urandom, $urandom_range(1));
  endfunction

  // Returns once nothing is queued, held or outstanding, and after a settling wait.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || start_i || expected_status.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_lead(logic [15:0] v);
    @(posedge clk_i);
    min_lead_we_i <= 1'b1;
    min_lead_i <= v;
    lead_reg = v;
    @(posedge clk_i);
    min_lead_we_i <= 1'b0;
  endtask

  initial begin
    int          gaps[5];
    logic [15:0] leads[5];
    gaps = '{0, 47, 0, 14, 47};
    leads = '{16'd50, 16'd1, 16'hFFFF, 16'd7, 16'($urandom_range(65535, 1))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: early service, empty disarm, zero and extreme delays,
    // head removal, a periodic re-queue, a repeating arm of zero and a full queue.
    pending_reqs.push_back(mk(CMD_SERVICE, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_DISARM, 3, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_TICK, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_ARM, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_ARM, 15, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(CMD_ARM, 5, 32'd100, 1'b1));
    pending_reqs.push_back(mk(CMD_ARM, 6, 32'd0, 1'b1));
    pending_reqs.push_back(mk(CMD_SERVICE, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_DISARM, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_TICK, 0, 32'd60, 1'b0));
    pending_reqs.push_back(mk(CMD_SERVICE, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_SERVICE, 0, '0, 1'b0));
    pending_reqs.push_back(mk(CMD_TICK, 0, 32'd100, 1'b0));
    pending_reqs.push_back(mk(CMD_SERVICE, 0, '0, 1'b0));
    for (int i = 0; i < NumSlots; i++)
      pending_reqs.push_back(mk(CMD_ARM, i, 32'(i % 4) * 32'd10, 1'b0));
    pending_reqs.push_back(mk(CMD_TICK, 0, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(CMD_SERVICE, 0, '0, 1'b0));
    wait_quiet();

    // Random phases, each at its own lead and sender idling. The sender stops in the
    // middle of every phase until every status has come back.
    for (int p = 0; p < 5; p++) begin
      write_lead(leads[p]);
      sender_gap_pct = gaps[p];
      for (int half = 0; half < 2; half++) begin
        for (int k = 0; k < 143; k++) pending_reqs.push_back(random_request());
        wait_quiet();
      end
    end

    $display("Run covered %0d requests over five lead settings, %0d timers fired.",
             accepted_count, fired_count);
    if (error_count == 0) begin
      $display("tb_sorted_software_timer_queue: done, clean");
    end else begin
      $display("tb_sorted_software_timer_queue: done, errors");
    end
    $finish;
  end

endmodule
